>>> hw/rtl/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg - shared types and constants for the 3x3 RGB box blur
// Pixel packing, column-sum record, CSR indexes, item opcodes and the
// rounding mean used on each 3x3 window.
// ----------------------------------------------------------------------------
package bblur_pkg;

   localparam int PIX_W       = 8;
   localparam int COL_SUM_W   = 10;   // up to 3 pixels
   localparam int WIN_SUM_W   = 12;   // up to 9 pixels
   localparam int CNT_W       = 4;    // pixel count 1..9
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int RECIP_W     = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // floor(y/3) = (y*5462) >> 14 for y < 8192; floor(y/9) = (y*3641) >> 15 for y < 32768
   localparam logic [RECIP_W-1:0] RECIP_3 = 13'd5462;
   localparam logic [RECIP_W-1:0] RECIP_9 = 13'd3641;
   localparam logic [3:0]         SHIFT_3 = 4'd14;
   localparam logic [3:0]         SHIFT_9 = 4'd15;

   // red in the top byte, blue in the bottom byte
   typedef logic [3*PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic                 ok;
      logic [COL_SUM_W-1:0] red;
      logic [COL_SUM_W-1:0] green;
      logic [COL_SUM_W-1:0] blue;
   } col_type;

   function automatic logic [COL_SUM_W-1:0] add3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                 logic [PIX_W-1:0] c, logic a_ok,
                                                 logic c_ok);
      logic [COL_SUM_W-1:0] s;
      s = COL_SUM_W'(b);
      if (a_ok) begin
         s = s + COL_SUM_W'(a);
      end
      if (c_ok) begin
         s = s + COL_SUM_W'(c);
      end
      return s;
   endfunction

   // vertical sum of one column: middle row always in frame
   function automatic col_type col_sum(pixel_type top, pixel_type mid, pixel_type bot,
                                       logic top_ok, logic bot_ok);
      col_type c;
      c.ok    = 1'b1;
      c.red   = add3(top[2*PIX_W +: PIX_W], mid[2*PIX_W +: PIX_W], bot[2*PIX_W +: PIX_W],
                     top_ok, bot_ok);
      c.green = add3(top[PIX_W +: PIX_W], mid[PIX_W +: PIX_W], bot[PIX_W +: PIX_W],
                     top_ok, bot_ok);
      c.blue  = add3(top[0 +: PIX_W], mid[0 +: PIX_W], bot[0 +: PIX_W], top_ok, bot_ok);
      return c;
   endfunction

   // (2*sum + cnt) / (2*cnt), cnt is one of 1, 2, 3, 4, 6, 9
   function automatic logic [PIX_W-1:0] mean_round(logic [WIN_SUM_W-1:0] sum,
                                                   logic [CNT_W-1:0] cnt);
      logic [WIN_SUM_W:0]           x;
      logic [WIN_SUM_W-1:0]         y;
      logic [RECIP_W-1:0]           m;
      logic [3:0]                   sh;
      logic [WIN_SUM_W+RECIP_W-1:0] prod;
      x  = {sum, 1'b0} + (WIN_SUM_W+1)'(cnt);
      y  = '0;
      m  = RECIP_W'(1);
      sh = '0;
      case (cnt)
         4'd1: begin
            y = x[WIN_SUM_W:1];
         end
         4'd2: begin
            y = WIN_SUM_W'(x >> 2);
         end
         4'd3: begin
            y  = x[WIN_SUM_W:1];
            m  = RECIP_3;
            sh = SHIFT_3;
         end
         4'd4: begin
            y = WIN_SUM_W'(x >> 3);
         end
         4'd6: begin
            y  = WIN_SUM_W'(x >> 2);
            m  = RECIP_3;
            sh = SHIFT_3;
         end
         4'd9: begin
            y  = x[WIN_SUM_W:1];
            m  = RECIP_9;
            sh = SHIFT_9;
         end
         default: begin
            y = '0;
         end
      endcase
      prod = {{RECIP_W{1'b0}}, y} * {{WIN_SUM_W{1'b0}}, m};
      return PIX_W'(prod >> sh);
   endfunction

endpackage

>>> hw/rtl/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb - streaming 3x3 per-channel box blur of raster-order RGB
// Result path: IDLE takes the releasing transfer, then LOAD0 (column 0 only),
//   LOAD1, SUM and DIV, and DIV loads the output register once it is free.
// Items that release nothing keep IDLE; a releasing one holds off input until DIV.
// Reset: synchronous; counters and handshakes cleared, frame 640x480; banks kept.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bblur_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bblur_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // input items
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [bblur_pkg::PIX_W-1:0]        req_in_red,
   input  logic [bblur_pkg::PIX_W-1:0]        req_in_green,
   input  logic [bblur_pkg::PIX_W-1:0]        req_in_blue,
   // results
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bblur_pkg::PIX_W-1:0]        rsp_out_red,
   output logic [bblur_pkg::PIX_W-1:0]        rsp_out_green,
   output logic [bblur_pkg::PIX_W-1:0]        rsp_out_blue,
   output logic                               rsp_frame_last
);
   import bblur_pkg::*;

   // Pixel history lives in four row banks, bank = row mod 4. While output row r
   // is built the input can already be on row r+2, so rows r-1..r+2 must coexist.
   // Each bank is a 1R1W synchronous memory with a registered read. A result
   // reads one column (three banks at once) per cycle and keeps a two-column window
   // of vertical sums, so each output past column 0 costs one new column read.
   // Writes happen only in IDLE and reads in the cycles after, so a column read
   // always sees the pixel written by the transfer that released it.

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = COL_W + 1;
   localparam int ROW_W  = ($clog2(MAX_HEIGHT + 1) > 2) ? $clog2(MAX_HEIGHT + 1) : 2;
   localparam int BANKS  = 4;
   localparam int BANK_W = 2;
   localparam int RST_W  = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;
   localparam int RST_H  = (RESET_HEIGHT < MAX_HEIGHT) ? RESET_HEIGHT : MAX_HEIGHT;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;   // take a transfer, write the pixel
   localparam logic [2:0] ST_LOAD0 = 3'd1;   // row start: read column 0
   localparam logic [2:0] ST_LOAD1 = 3'd2;   // read column c+1
   localparam logic [2:0] ST_SUM   = 3'd3;   // 3x3 sums and pixel count
   localparam logic [2:0] ST_DIV   = 3'd4;   // rounded mean into the output register

   logic [2:0]           state_ff, state_in;
   logic [WID_W-1:0]     width_ff, width_in;
   logic [ROW_W-1:0]     height_ff, height_in;
   logic [ROW_W-1:0]     in_row_ff, in_row_in;
   logic [COL_W-1:0]     in_col_ff, in_col_in;
   logic [ROW_W-1:0]     out_row_ff, out_row_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;

   // position of the result being built
   logic [ROW_W-1:0]     cur_row_ff, cur_row_in;
   logic [COL_W-1:0]     cur_col_ff, cur_col_in;
   logic                 first_ff, first_in;
   logic                 last_ff, last_in;

   col_type              win_prev_ff, win_prev_in;
   col_type              win_cur_ff, win_cur_in;
   logic [WIN_SUM_W-1:0] sum_red_ff, sum_red_in;
   logic [WIN_SUM_W-1:0] sum_green_ff, sum_green_in;
   logic [WIN_SUM_W-1:0] sum_blue_ff, sum_blue_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]     rsp_red_ff, rsp_red_in;
   logic [PIX_W-1:0]     rsp_green_ff, rsp_green_in;
   logic [PIX_W-1:0]     rsp_blue_ff, rsp_blue_in;
   logic                 rsp_last_ff, rsp_last_in;

   // bank ports
   logic                         mem_we;
   logic [BANK_W-1:0]            wr_bank;
   logic [COL_W-1:0]             wr_addr;
   pixel_type                    wr_data;
   logic                         rd_en;
   logic [COL_W-1:0]             rd_addr;
   logic [BANKS-1:0][3*PIX_W-1:0] rd_pix;

   // transfer decode
   logic                 csr_go;
   logic                 req_go;
   logic                 pix_go;
   logic                 restart;
   logic [ROW_W-1:0]     row_eff;
   logic [COL_W-1:0]     col_eff;
   logic [ROW_W-1:0]     orow_eff;
   logic [COL_W-1:0]     ocol_eff;
   logic [WID_W-1:0]     col_step;
   logic [ROW_W-1:0]     in_row_nx;
   logic [COL_W-1:0]     in_col_nx;
   logic [ROW_W-1:0]     orow_inc;
   logic [WID_W-1:0]     ocol_inc;
   logic [ROW_W-1:0]     need_row;
   logic [WID_W-1:0]     need_col;
   logic                 out_ready;

   // column assembly
   logic [BANK_W-1:0]    slot_top, slot_mid, slot_bot;
   logic                 top_ok, bot_ok, nxt_ok;
   col_type              rd_col;
   col_type              nxt_col;
   logic [1:0]           rows_n, cols_n;

   assign csr_ready = (state_ff == ST_IDLE);
   // a CSR write wins over an item in the same cycle
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_go    = csr_valid && csr_ready;
   assign req_go    = req_valid && req_ready;
   assign pix_go    = req_go && (req_op == OP_PIXEL);

   // a pixel after the frame's end opens a new frame and drops what is pending
   assign restart  = pix_go && (in_row_ff >= height_ff);
   assign row_eff  = restart ? '0 : in_row_ff;
   assign col_eff  = restart ? '0 : in_col_ff;
   assign orow_eff = restart ? '0 : out_row_ff;
   assign ocol_eff = restart ? '0 : out_col_ff;

   // input position after this transfer
   always_comb begin
      col_step  = {1'b0, col_eff} + WID_W'(1);
      in_row_nx = row_eff;
      in_col_nx = col_eff;
      if (pix_go) begin
         if (col_step >= width_ff) begin
            in_col_nx = '0;
            in_row_nx = row_eff + ROW_W'(1);
         end else begin
            in_col_nx = col_step[COL_W-1:0];
         end
      end
   end

   // output (r,c) is ready once input has passed (min(r+1,H-1), min(c+1,W-1))
   assign orow_inc  = orow_eff + ROW_W'(1);
   assign ocol_inc  = {1'b0, ocol_eff} + WID_W'(1);
   assign need_row  = (orow_inc < height_ff) ? orow_inc : height_ff - ROW_W'(1);
   assign need_col  = (ocol_inc < width_ff) ? ocol_inc : width_ff - WID_W'(1);
   assign out_ready = (orow_eff < height_ff) &&
                      ((in_row_nx > need_row) ||
                       ((in_row_nx == need_row) && ({1'b0, in_col_nx} > need_col)));

   // bank access
   assign mem_we  = pix_go;
   assign wr_bank = row_eff[BANK_W-1:0];
   assign wr_addr = col_eff;
   assign wr_data = {req_in_red, req_in_green, req_in_blue};
   assign rd_en   = (state_ff == ST_LOAD0) || (state_ff == ST_LOAD1);
   assign rd_addr = (state_ff == ST_LOAD0) ? '0 : cur_col_ff + COL_W'(1);

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      pixel_type bank_mem [MAX_WIDTH];
      pixel_type bank_rd_ff;

      always_ff @(posedge clock) begin
         if (mem_we && (wr_bank == BANK_W'(b))) begin
            bank_mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            bank_rd_ff <= bank_mem[rd_addr];
         end
      end

      assign rd_pix[b] = bank_rd_ff;
   end

   // rows r-1, r, r+1 of the current result, clipped to the frame
   assign slot_mid = cur_row_ff[BANK_W-1:0];
   assign slot_top = slot_mid - BANK_W'(1);
   assign slot_bot = slot_mid + BANK_W'(1);
   assign top_ok   = (cur_row_ff != '0);
   assign bot_ok   = ((cur_row_ff + ROW_W'(1)) < height_ff);
   assign nxt_ok   = (({1'b0, cur_col_ff} + WID_W'(1)) < width_ff);
   assign rd_col   = col_sum(rd_pix[slot_top], rd_pix[slot_mid], rd_pix[slot_bot],
                             top_ok, bot_ok);
   // column past the right edge counts as empty
   assign nxt_col  = nxt_ok ? rd_col : '0;
   assign rows_n   = 2'd1 + {1'b0, top_ok} + {1'b0, bot_ok};
   assign cols_n   = {1'b0, win_prev_ff.ok} + {1'b0, win_cur_ff.ok} + {1'b0, nxt_col.ok};

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      win_prev_in  = win_prev_ff;
      win_cur_in   = win_cur_ff;
      sum_red_in   = sum_red_ff;
      sum_green_in = sum_green_ff;
      sum_blue_in  = sum_blue_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_go) begin
               // size write clamps to 1..MAX and restarts the frame
               if (csr_index == CSR_FRAME_WIDTH) begin
                  if (csr_wdata == '0) begin
                     width_in = WID_W'(1);
                  end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                     width_in = WID_W'(MAX_WIDTH);
                  end else begin
                     width_in = WID_W'(csr_wdata);
                  end
               end else if (csr_index == CSR_FRAME_HEIGHT) begin
                  if (csr_wdata == '0) begin
                     height_in = ROW_W'(1);
                  end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
                     height_in = ROW_W'(MAX_HEIGHT);
                  end else begin
                     height_in = ROW_W'(csr_wdata);
                  end
               end
               if ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT)) begin
                  in_row_in  = '0;
                  in_col_in  = '0;
                  out_row_in = '0;
                  out_col_in = '0;
               end
            end else if (req_go) begin
               in_row_in  = in_row_nx;
               in_col_in  = in_col_nx;
               out_row_in = orow_eff;
               out_col_in = ocol_eff;
               if (out_ready) begin
                  cur_row_in = orow_eff;
                  cur_col_in = ocol_eff;
                  first_in   = (ocol_eff == '0);
                  last_in    = (orow_eff == height_ff - ROW_W'(1)) && (ocol_inc == width_ff);
                  if (ocol_inc >= width_ff) begin
                     out_col_in = '0;
                     out_row_in = orow_inc;
                  end else begin
                     out_col_in = ocol_inc[COL_W-1:0];
                  end
                  state_in = (ocol_eff == '0) ? ST_LOAD0 : ST_LOAD1;
               end
            end
         end
         ST_LOAD0: begin
            state_in = ST_LOAD1;
         end
         ST_LOAD1: begin
            // column 0 has arrived: window starts with an empty left column
            if (first_ff) begin
               win_prev_in = '0;
               win_cur_in  = rd_col;
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_red_in   = WIN_SUM_W'(win_prev_ff.red) + WIN_SUM_W'(win_cur_ff.red) +
                           WIN_SUM_W'(nxt_col.red);
            sum_green_in = WIN_SUM_W'(win_prev_ff.green) + WIN_SUM_W'(win_cur_ff.green) +
                           WIN_SUM_W'(nxt_col.green);
            sum_blue_in  = WIN_SUM_W'(win_prev_ff.blue) + WIN_SUM_W'(win_cur_ff.blue) +
                           WIN_SUM_W'(nxt_col.blue);
            cnt_in       = CNT_W'(rows_n) * CNT_W'(cols_n);
            win_prev_in  = win_cur_ff;
            win_cur_in   = nxt_col;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = mean_round(sum_red_ff, cnt_ff);
               rsp_green_in = mean_round(sum_green_ff, cnt_ff);
               rsp_blue_in  = mean_round(sum_blue_ff, cnt_ff);
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WID_W'(RST_W);
         height_ff    <= ROW_W'(RST_H);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      win_prev_ff  <= win_prev_in;
      win_cur_ff   <= win_cur_in;
      sum_red_ff   <= sum_red_in;
      sum_green_ff <= sum_green_in;
      sum_blue_ff  <= sum_blue_in;
      cnt_ff       <= cnt_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_red_ff;
   assign rsp_out_green  = rsp_green_ff;
   assign rsp_out_blue   = rsp_blue_ff;
   assign rsp_frame_last = rsp_last_ff;

`ifndef ASSERT_OFF
   // results never overtake the input stream
   a_out_behind_in: assert property (@(posedge clock) disable iff (reset)
      out_row_ff <= in_row_ff)
      else $error("output row ahead of input row");

   // window count must be one of the shapes a clipped 3x3 square can take
   a_cnt_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ((cnt_ff == CNT_W'(1)) || (cnt_ff == CNT_W'(2)) ||
                                (cnt_ff == CNT_W'(3)) || (cnt_ff == CNT_W'(4)) ||
                                (cnt_ff == CNT_W'(6)) || (cnt_ff == CNT_W'(9))))
      else $error("illegal window pixel count");

   // a new result only comes out of the divide step
   a_rsp_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DIV))
      else $error("result raised outside divide step");

   // a stalled result is not overwritten
   a_div_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && rsp_valid_ff && !rsp_ready) |=>
         ((state_ff == ST_DIV) && rsp_valid_ff))
      else $error("divide step left while output register busy");
`endif

endmodule

>>> dv/tb_box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb - self-checking bench for the streaming 3x3 RGB box blur
// Feeds pixel and drain transfers from a queue, mirrors the blur in a
// bit-exact predictor and compares every result transfer in arrival order.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb;
   import bblur_pkg::*;

   // predictor sizes track the instance defaults
   localparam int unsigned MAX_W = 1024;
   localparam int unsigned MAX_H = 4096;

   // CSR slots past the defined registers; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int unsigned IDLE_PCT      = 19;      // idle/stall odds per cycle, in %
   localparam int unsigned SETTLE_CYCLES = 12;      // quiet cycles before a CSR write
   localparam int unsigned TAIL_CYCLES   = 40;      // watch for stray results at the end
   localparam int unsigned CYCLE_LIMIT   = 500000;  // timeout
   localparam int unsigned RANDOM_ITEMS  = 250;

   // what the feeder does with the head of the queue
   typedef enum logic [1:0] {
      STEP_ITEM,     // one pixel or drain transfer
      STEP_CSR,      // register write, issued only with nothing in flight
      STEP_SETTLE,   // hold off until every expected result is back
      STEP_FLUSH     // keep sending drains while an output is due
   } step_kind_type;

   typedef struct {
      step_kind_type            kind;
      logic                     op;
      logic [PIX_W-1:0]         red;
      logic [PIX_W-1:0]         green;
      logic [PIX_W-1:0]         blue;
      logic [CSR_INDEX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]    data;
   } step_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             last;
   } blurred_pixel_type;

   // ------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic                   req_op         = OP_PIXEL;
   logic [PIX_W-1:0]       req_in_red     = '0;
   logic [PIX_W-1:0]       req_in_green   = '0;
   logic [PIX_W-1:0]       req_in_blue    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [PIX_W-1:0]       rsp_out_red;
   logic [PIX_W-1:0]       rsp_out_green;
   logic [PIX_W-1:0]       rsp_out_blue;
   logic                   rsp_frame_last;

   box_blur_3x3_rgb dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_last (rsp_frame_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Blur predictor. Four row slots (row mod 4) hold the pixel history; the
   // window always spans the output row and its two neighbors, all of which
   // were written in the current frame by the time the output is due.
   // ------------------------------------------------------------------------
   pixel_type         row_hist [4][MAX_W];
   int unsigned       frame_w = RESET_WIDTH;
   int unsigned       frame_h = RESET_HEIGHT;
   int unsigned       in_row, in_col, out_row, out_col;
   blurred_pixel_type blurred_q [$];       // results still owed by the DUT

   int unsigned    errors;
   int unsigned    sent_items;             // accepted req transfers
   int unsigned    cycle_count;
   logic           steady;                 // no idling on either side

   // one no-idle stretch, well inside the run
   assign steady = (sent_items >= 300) && (sent_items < 800);

   function automatic void restart_frame();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
   endfunction

   // output (r,c) is due once input (min(r+1,H-1), min(c+1,W-1)) has landed
   function automatic bit output_due();
      int unsigned nr, nc;
      if (out_row >= frame_h) begin
         return 1'b0;
      end
      nr = (out_row + 1 < frame_h) ? out_row + 1 : frame_h - 1;
      nc = (out_col + 1 < frame_w) ? out_col + 1 : frame_w - 1;
      return (in_row > nr) || (in_row == nr && in_col > nc);
   endfunction

   // mean over the in-frame part of the 3x3 square, rounded half up
   function automatic void release_output();
      int unsigned       sum_r, sum_g, sum_b, n;
      int                y, x;
      pixel_type         p;
      blurred_pixel_type b;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      n     = 0;
      for (y = int'(out_row) - 1; y <= int'(out_row) + 1; y++) begin
         if (y < 0 || y >= int'(frame_h)) begin
            continue;
         end
         for (x = int'(out_col) - 1; x <= int'(out_col) + 1; x++) begin
            if (x < 0 || x >= int'(frame_w)) begin
               continue;
            end
            p = row_hist[y % 4][x];
            sum_r += p[2*PIX_W +: PIX_W];
            sum_g += p[PIX_W +: PIX_W];
            sum_b += p[0 +: PIX_W];
            n++;
         end
      end
      b.red   = PIX_W'((2 * sum_r + n) / (2 * n));
      b.green = PIX_W'((2 * sum_g + n) / (2 * n));
      b.blue  = PIX_W'((2 * sum_b + n) / (2 * n));
      b.last  = (out_row == frame_h - 1) && (out_col == frame_w - 1);
      blurred_q.push_back(b);
      out_col++;
      if (out_col >= frame_w) begin
         out_col = 0;
         out_row++;
      end
   endfunction

   // one accepted req transfer; at most one output leaves per transfer
   function automatic void predict_item(logic op, pixel_type pix);
      if (op == OP_PIXEL) begin
         // a pixel after a finished frame opens the next one; undrained
         // outputs of the old frame are lost
         if (in_row >= frame_h) begin
            restart_frame();
         end
         row_hist[in_row % 4][in_col] = pix;
         in_col++;
         if (in_col >= frame_w) begin
            in_col = 0;
            in_row++;
         end
      end
      if (output_due()) begin
         release_output();
      end
   endfunction

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v == 0) begin
         return 1;
      end
      return (v > hi) ? hi : v;
   endfunction

   // size writes clamp and restart the frame; spare indexes change nothing
   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx,
                                     logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_FRAME_WIDTH: begin
            frame_w = clamp_size(data, MAX_W);
            restart_frame();
         end
         CSR_FRAME_HEIGHT: begin
            frame_h = clamp_size(data, MAX_H);
            restart_frame();
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus queue and the helpers that fill it
   // ------------------------------------------------------------------------
   step_type    pending_steps [$];
   int unsigned queued_items;

   function automatic logic [PIX_W-1:0] rand_chan();
      // lean on the rails so rounding at full scale gets exercised
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   function automatic void push_item(logic op, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                     logic [PIX_W-1:0] b);
      step_type s;
      s.kind  = STEP_ITEM;
      s.op    = op;
      s.red   = r;
      s.green = g;
      s.blue  = b;
      s.index = CSR_FRAME_WIDTH;
      s.data  = '0;
      pending_steps.push_back(s);
      queued_items++;
   endfunction

   function automatic void push_pixel();
      push_item(OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
   endfunction

   // drain payload is don't-care; randomize it anyway
   function automatic void push_drain();
      push_item(OP_DRAIN, rand_chan(), rand_chan(), rand_chan());
   endfunction

   function automatic void push_ctrl(step_kind_type kind, logic [CSR_INDEX_W-1:0] idx,
                                     int unsigned value);
      step_type s;
      s.kind  = kind;
      s.op    = OP_DRAIN;
      s.red   = '0;
      s.green = '0;
      s.blue  = '0;
      s.index = idx;
      s.data  = CSR_DATA_W'(value);
      pending_steps.push_back(s);
   endfunction

   // One frame of random pixels. Mostly a clean frame followed by a full
   // drain; some frames sprinkle drains mid-frame, some stop draining early
   // so the next frame drops the leftovers, and the last frame before a size
   // change may be cut short.
   function automatic void add_frame(int unsigned w, int unsigned h, bit may_cut);
      int unsigned total, count, style, i;
      total = w * h;
      style = $urandom_range(99);
      count = total;
      if (may_cut && style >= 92) begin
         count = $urandom_range(total, 1);
      end
      for (i = 0; i < count; i++) begin
         push_pixel();
         if (style >= 70 && style < 80 && $urandom_range(99) < 15) begin
            push_drain();
         end
      end
      if (count < total) begin
         return;
      end
      if (style >= 80 && style < 92) begin
         repeat ($urandom_range(3)) push_drain();
      end else begin
         push_ctrl(STEP_FLUSH, CSR_FRAME_WIDTH, 0);
         // drains with nothing left must stay silent
         if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(2, 1)) push_drain();
         end
      end
   endfunction

   function automatic void build_stimulus();
      int unsigned cur_w, cur_h, w, h, wv, hv, sel, frames, f, target;

      // --- directed ---
      // default 640x480: nothing can come out yet, a drain stays silent
      push_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      push_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
      push_item(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
      push_drain();
      // spare CSR slots leave the frame running
      push_ctrl(STEP_CSR, CSR_SPARE_2, 13'h1FFF);
      push_ctrl(STEP_CSR, CSR_SPARE_3, 13'h0AAA);
      push_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
      // 1x1 frame: every pixel is its own frame and carries frame_last
      push_ctrl(STEP_CSR, CSR_FRAME_WIDTH, 1);
      push_ctrl(STEP_CSR, CSR_FRAME_HEIGHT, 1);
      push_item(OP_PIXEL, 8'h12, 8'h34, 8'h56);
      push_drain();
      push_item(OP_PIXEL, 8'hFF, 8'h80, 8'h7F);
      // 3x3 checkerboard: corners average 4, edges 6, center 9
      push_ctrl(STEP_CSR, CSR_FRAME_WIDTH, 3);
      push_ctrl(STEP_CSR, CSR_FRAME_HEIGHT, 3);
      for (int i = 0; i < 6; i++) begin
         push_item(OP_PIXEL, (i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF, 8'hFF);
      end
      push_drain();                                    // drain mid-frame with one due
      push_ctrl(STEP_SETTLE, CSR_FRAME_WIDTH, 0);      // sender waits for the DUT
      for (int i = 6; i < 9; i++) begin
         push_item(OP_PIXEL, (i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF, 8'h01);
      end
      push_drain();
      push_drain();
      push_item(OP_PIXEL, 8'h80, 8'h81, 8'h7F);        // new frame drops the last two

      // --- largest sizes, kept short ---
      push_ctrl(STEP_CSR, CSR_FRAME_WIDTH, 2047);      // clamps to 1024
      push_ctrl(STEP_CSR, CSR_FRAME_HEIGHT, 1);
      add_frame(MAX_W, 1, 1'b0);
      push_ctrl(STEP_CSR, CSR_FRAME_HEIGHT, 8191);     // clamps to 4096
      push_ctrl(STEP_CSR, CSR_FRAME_WIDTH, 0);         // acts as 1
      repeat (100) push_pixel();
      push_ctrl(STEP_CSR, CSR_FRAME_WIDTH, MAX_W);
      push_ctrl(STEP_CSR, CSR_FRAME_HEIGHT, MAX_H);
      repeat (40) push_pixel();
      cur_w = MAX_W;
      cur_h = MAX_H;

      // --- random phases, mostly small frames ---
      target = queued_items + RANDOM_ITEMS;
      while (queued_items < target) begin
         sel = $urandom_range(99);
         if (sel < 45) begin
            w = $urandom_range(8, 1);
            h = $urandom_range(6, 1);
         end else if (sel < 80) begin
            w = $urandom_range(24, 2);
            h = $urandom_range(10, 2);
         end else begin
            w = $urandom_range(90, 25);
            h = $urandom_range(4, 1);
         end
         wv = w;
         hv = h;
         if ($urandom_range(99) < 8) begin
            wv = 0;
            w  = 1;
         end
         if ($urandom_range(99) < 8) begin
            hv = 0;
            h  = 1;
         end
         sel = $urandom_range(99);
         if (sel < 10 && cur_h <= 10) begin
            push_ctrl(STEP_CSR, CSR_FRAME_WIDTH, wv);
            h = cur_h;
         end else if (sel < 20 && cur_w <= 90) begin
            push_ctrl(STEP_CSR, CSR_FRAME_HEIGHT, hv);
            w = cur_w;
         end else if (sel < 60) begin
            push_ctrl(STEP_CSR, CSR_FRAME_WIDTH, wv);
            push_ctrl(STEP_CSR, CSR_FRAME_HEIGHT, hv);
         end else begin
            push_ctrl(STEP_CSR, CSR_FRAME_HEIGHT, hv);
            push_ctrl(STEP_CSR, CSR_FRAME_WIDTH, wv);
         end
         if ($urandom_range(99) < 10) begin
            push_ctrl(STEP_CSR, $urandom_range(1) ? CSR_SPARE_3 : CSR_SPARE_2,
                      $urandom_range(8191));
         end
         cur_w  = w;
         cur_h  = h;
         frames = $urandom_range(4, 1);
         for (f = 0; f < frames; f++) begin
            add_frame(cur_w, cur_h, f == frames - 1);
            if ($urandom_range(99) < 10) begin
               push_ctrl(STEP_SETTLE, CSR_FRAME_WIDTH, 0);
            end
         end
      end
   endfunction

   function automatic bit sender_pauses();
      return !steady && ($urandom_range(99) < IDLE_PCT);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: retires the transfer in flight, then loads the next step. The
   // predictor runs on the accepting edge, so FLUSH and the quiet counter see
   // the state that includes every transfer so far. Each valid gets exactly
   // one nonblocking write per edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : feed
      step_type    nxt;
      logic        req_hold;
      logic        csr_hold;
      int unsigned quiet_cycles;
      if (reset) begin
         req_valid    <= 1'b0;
         csr_valid    <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_hold = req_valid;
         csr_hold = csr_valid;
         if (blurred_q.size() == 0 && !req_valid) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
         if (req_valid && req_ready) begin
            predict_item(req_op, {req_in_red, req_in_green, req_in_blue});
            req_hold = 1'b0;
            sent_items++;
         end
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_wdata);
            csr_hold = 1'b0;
         end
         if (!req_hold && !csr_hold && pending_steps.size() != 0) begin
            nxt = pending_steps[0];
            case (nxt.kind)
               STEP_ITEM: begin
                  if (!sender_pauses()) begin
                     void'(pending_steps.pop_front());
                     req_op       <= nxt.op;
                     req_in_red   <= nxt.red;
                     req_in_green <= nxt.green;
                     req_in_blue  <= nxt.blue;
                     req_hold     = 1'b1;
                  end
               end
               STEP_FLUSH: begin
                  if (!output_due()) begin
                     void'(pending_steps.pop_front());
                  end else if (!sender_pauses()) begin
                     req_op       <= OP_DRAIN;
                     req_in_red   <= rand_chan();
                     req_in_green <= rand_chan();
                     req_in_blue  <= rand_chan();
                     req_hold     = 1'b1;
                  end
               end
               STEP_CSR: begin
                  // DUT has been idle long enough to cover its pipeline
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     void'(pending_steps.pop_front());
                     csr_index <= nxt.index;
                     csr_wdata <= nxt.data;
                     csr_hold  = 1'b1;
                  end
               end
               default: begin
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     void'(pending_steps.pop_front());
                  end
               end
            endcase
         end
         req_valid <= req_hold;
         csr_valid <= csr_hold;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every result transfer against the oldest expectation
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      blurred_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (blurred_q.size() == 0) begin
            $display("%0t: result with nothing expected, actual r=%0d g=%0d b=%0d last=%0d",
                     $time, rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_last);
            errors++;
         end else begin
            want = blurred_q.pop_front();
            check_field("out_red", want.red, rsp_out_red);
            check_field("out_green", want.green, rsp_out_green);
            check_field("out_blue", want.blue, rsp_out_blue);
            check_field("frame_last", want.last, rsp_frame_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencing: build the queue, release reset, wait for everything to drain
   // ------------------------------------------------------------------------
   initial begin
      build_stimulus();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (pending_steps.size() != 0 || req_valid || csr_valid) begin
         @(posedge clock);
      end
      while (blurred_q.size() != 0) begin
         @(posedge clock);
      end
      // anything arriving now is a stray result
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
